// ===== rtl/cro_pkg.sv =====
// ----------------------------------------------------------------------------
// cro_pkg - shared types and constants of the circle rasteriser
// Field widths, action codes and the step record passed from front to back.
// ----------------------------------------------------------------------------
package cro_pkg;

	localparam int COORD_BITS_DEF = 12;  // default width of a held centre
	localparam int IN_COORD_W     = 12;  // centre fields on the input beat
	localparam int RADIUS_W       = 11;
	localparam int STEP_W         = 11;
	localparam int DEC_W          = 16;
	localparam int POINT_W        = 14;
	localparam int IN_TDATA_W     = 40;  // 12 + 12 + 11, padded to bytes
	localparam int OUT_TDATA_W    = 32;  // 14 + 14, padded to bytes
	localparam int QUEUE_DEPTH    = 2;
	localparam int PTS_PER_STEP   = 8;
	localparam int PT_IDX_W       = $clog2(PTS_PER_STEP);

	typedef enum logic {
		ACT_START   = 1'b0,
		ACT_ADVANCE = 1'b1
	} action_t;

	// Octant point order within one step
	typedef enum logic [PT_IDX_W-1:0] {
		PT_XP_YP = 3'd0,
		PT_XP_YN = 3'd1,
		PT_YP_XP = 3'd2,
		PT_YP_XN = 3'd3,
		PT_XN_YN = 3'd4,
		PT_YN_XN = 3'd5,
		PT_XN_YP = 3'd6,
		PT_YN_XP = 3'd7
	} pt_idx_t;

	typedef struct packed {
		logic [STEP_W-1:0] x;
		logic [STEP_W-1:0] y;
		logic              done;
	} step_t;

endpackage

// ===== rtl/cro_queue.sv =====
// ----------------------------------------------------------------------------
// cro_queue - small register queue between front and back
// Push and pop in the same cycle are allowed; head is read from the array.
// ----------------------------------------------------------------------------
module cro_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/cro_front.sv =====
// ----------------------------------------------------------------------------
// cro_front - accepts actions and runs the midpoint decision update
// Produces one step record (centre, x, y, done) per start or live advance.
// ----------------------------------------------------------------------------
module cro_front
	import cro_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  action_t               action,
	input  logic [IN_COORD_W-1:0] center_x,
	input  logic [IN_COORD_W-1:0] center_y,
	input  logic [RADIUS_W-1:0]   radius,
	input  logic                  q_full,
	output logic                  push,
	output logic [COORD_BITS-1:0] push_cx,
	output logic [COORD_BITS-1:0] push_cy,
	output step_t                 push_step
);

	logic [STEP_W-1:0]      step_x_q;
	logic [STEP_W-1:0]      step_y_q;
	logic signed [DEC_W-1:0] decision_q;
	logic [COORD_BITS-1:0]  held_cx_q;
	logic [COORD_BITS-1:0]  held_cy_q;
	logic                   active_q;

	logic                   accept;
	logic                   is_start;
	logic [STEP_W-1:0]      x_inc;
	logic [STEP_W-1:0]      y_dec;
	logic [STEP_W-1:0]      x_nxt;
	logic [STEP_W-1:0]      y_nxt;
	logic [DEC_W-1:0]       d_nxt;
	logic [DEC_W-1:0]       diff;
	logic                   done_nxt;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_start = (action == ACT_START);

	assign x_inc = step_x_q + 1'b1;
	assign y_dec = step_y_q - 1'b1;
	assign diff  = DEC_W'(x_inc) - DEC_W'(y_dec);

	always_comb begin
		if (is_start) begin
			x_nxt = '0;
			y_nxt = STEP_W'(radius);
			d_nxt = DEC_W'(3) - DEC_W'({radius, 1'b0});
		end else if (decision_q[DEC_W-1]) begin
			x_nxt = x_inc;
			y_nxt = step_y_q;
			d_nxt = decision_q + DEC_W'({x_inc, 2'b00}) + DEC_W'(6);
		end else begin
			x_nxt = x_inc;
			y_nxt = y_dec;
			d_nxt = decision_q + {diff[DEC_W-3:0], 2'b00} + DEC_W'(10);
		end
	end

	assign done_nxt = !(x_nxt < y_nxt);

	// an advance with no circle running is taken and dropped
	assign push = accept && (is_start || active_q);

	assign push_cx        = is_start ? COORD_BITS'(center_x) : held_cx_q;
	assign push_cy        = is_start ? COORD_BITS'(center_y) : held_cy_q;
	assign push_step.x    = x_nxt;
	assign push_step.y    = y_nxt;
	assign push_step.done = done_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q   <= '0;
			step_y_q   <= '0;
			decision_q <= '0;
			held_cx_q  <= '0;
			held_cy_q  <= '0;
			active_q   <= 1'b0;
		end else if (push) begin
			step_x_q   <= x_nxt;
			step_y_q   <= y_nxt;
			decision_q <= d_nxt;
			held_cx_q  <= push_cx;
			held_cy_q  <= push_cy;
			active_q   <= !done_nxt;
		end
	end

endmodule

// ===== rtl/cro_back.sv =====
// ----------------------------------------------------------------------------
// cro_back - mirrors a step record into eight points, one per unstalled cycle
// Output register holds the current point while the receiver stalls.
// ----------------------------------------------------------------------------
module cro_back
	import cro_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  logic [COORD_BITS-1:0]  q_cx,
	input  logic [COORD_BITS-1:0]  q_cy,
	input  step_t                  q_step,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [POINT_W-1:0]     point_x,
	output logic [POINT_W-1:0]     point_y,
	output logic                   last_of_step,
	output logic                   circle_done
);

	logic                  cur_valid_q;
	logic [COORD_BITS-1:0] cur_cx_q;
	logic [COORD_BITS-1:0] cur_cy_q;
	step_t                 cur_step_q;
	pt_idx_t               idx_q;

	logic                  out_valid_q;
	logic [POINT_W-1:0]    px_q;
	logic [POINT_W-1:0]    py_q;
	logic                  last_q;
	logic                  done_q;

	logic                  emit;
	logic                  last_pt;
	logic                  load;
	logic                  swap;
	logic                  x_neg;
	logic                  y_neg;
	logic [POINT_W-1:0]    cx_w;
	logic [POINT_W-1:0]    cy_w;
	logic [POINT_W-1:0]    u_w;
	logic [POINT_W-1:0]    v_w;
	logic [POINT_W-1:0]    px_nxt;
	logic [POINT_W-1:0]    py_nxt;

	assign emit    = cur_valid_q && (!out_valid_q || out_ready);
	assign last_pt = (idx_q == PT_YN_XP);
	assign load    = q_valid && (!cur_valid_q || (emit && last_pt));
	assign pop     = load;

	always_comb begin
		swap = 1'b0;
		x_neg = 1'b0;
		y_neg = 1'b0;
		case (idx_q)
			PT_XP_YP: begin swap = 1'b0; x_neg = 1'b0; y_neg = 1'b0; end
			PT_XP_YN: begin swap = 1'b0; x_neg = 1'b0; y_neg = 1'b1; end
			PT_YP_XP: begin swap = 1'b1; x_neg = 1'b0; y_neg = 1'b0; end
			PT_YP_XN: begin swap = 1'b1; x_neg = 1'b0; y_neg = 1'b1; end
			PT_XN_YN: begin swap = 1'b0; x_neg = 1'b1; y_neg = 1'b1; end
			PT_YN_XN: begin swap = 1'b1; x_neg = 1'b1; y_neg = 1'b1; end
			PT_XN_YP: begin swap = 1'b0; x_neg = 1'b1; y_neg = 1'b0; end
			PT_YN_XP: begin swap = 1'b1; x_neg = 1'b1; y_neg = 1'b0; end
			default:  begin swap = 1'b0; x_neg = 1'b0; y_neg = 1'b0; end
		endcase
	end

	// coordinates wrap at the output width, so only the low bits matter
	assign cx_w   = POINT_W'(cur_cx_q);
	assign cy_w   = POINT_W'(cur_cy_q);
	assign u_w    = swap ? POINT_W'(cur_step_q.y) : POINT_W'(cur_step_q.x);
	assign v_w    = swap ? POINT_W'(cur_step_q.x) : POINT_W'(cur_step_q.y);
	assign px_nxt = x_neg ? cx_w - u_w : cx_w + u_w;
	assign py_nxt = y_neg ? cy_w - v_w : cy_w + v_w;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_cx_q   <= q_cx;
			cur_cy_q   <= q_cy;
			cur_step_q <= q_step;
		end
		if (emit) begin
			px_q   <= px_nxt;
			py_q   <= py_nxt;
			last_q <= last_pt;
			done_q <= last_pt && cur_step_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= PT_XP_YP;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
				idx_q       <= PT_XP_YP;
			end else if (emit) begin
				if (last_pt) begin
					cur_valid_q <= 1'b0;
				end
				idx_q <= pt_idx_t'(idx_q + 1'b1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign point_x      = px_q;
	assign point_y      = py_q;
	assign last_of_step = last_q;
	assign circle_done  = done_q;

endmodule

// ===== rtl/circle_rasterizer_octant_core.sv =====
// ----------------------------------------------------------------------------
// circle_rasterizer_octant_core - midpoint circle generator, eight-way mirror
//
// Slave stream: one beat per action. tuser = action (start / advance); on a
// start tdata carries the centre and radius. A start loads a new circle and
// drops any running one; an advance moves one step along the octant; an
// advance with no circle running is taken and produces nothing.
// Master stream: eight beats per start or live advance, one pixel each.
// tlast marks the eighth point of a step, tuser is set on the eighth point
// of the step that finishes the circle.
// Throughput: one point per cycle while m_axis_tready is high; the back
// end's point counter walks the eight points of a step. The decision
// update runs in the cycle of acceptance; a two-entry queue lets input
// beats land while points drain. Path: queue, step and output registers.
// Stall: a low m_axis_tready holds the output register; the queue fills and
// s_axis_tready falls once two steps are waiting. Reset empties the queue
// and the output and leaves no circle running.
// ----------------------------------------------------------------------------
module circle_rasterizer_octant_core
	import cro_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // center_x, center_y, radius, pad
	input  logic                   s_axis_tuser,  // action
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // point_x, point_y, pad
	output logic                   m_axis_tlast,
	output logic                   m_axis_tuser   // circle_done
);

	localparam int REC_W = 2 * COORD_BITS + $bits(step_t);

	logic                  push;
	logic [COORD_BITS-1:0] push_cx;
	logic [COORD_BITS-1:0] push_cy;
	step_t                 push_step;
	logic                  q_full;
	logic                  q_valid;
	logic                  pop;
	logic [REC_W-1:0]      q_data;
	logic [COORD_BITS-1:0] q_cx;
	logic [COORD_BITS-1:0] q_cy;
	step_t                 q_step;
	logic [POINT_W-1:0]    point_x;
	logic [POINT_W-1:0]    point_y;
	action_t               action;

	assign action = action_t'(s_axis_tuser);

	cro_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.action    (action),
		.center_x  (s_axis_tdata[IN_COORD_W-1:0]),
		.center_y  (s_axis_tdata[2*IN_COORD_W-1:IN_COORD_W]),
		.radius    (s_axis_tdata[2*IN_COORD_W+RADIUS_W-1:2*IN_COORD_W]),
		.q_full    (q_full),
		.push      (push),
		.push_cx   (push_cx),
		.push_cy   (push_cy),
		.push_step (push_step)
	);

	cro_queue #(
		.WIDTH(REC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cx, push_cy, push_step}),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	assign {q_cx, q_cy, q_step} = q_data;

	cro_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cx         (q_cx),
		.q_cy         (q_cy),
		.q_step       (q_step),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.point_x      (point_x),
		.point_y      (point_y),
		.last_of_step (m_axis_tlast),
		.circle_done  (m_axis_tuser)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - 2 * POINT_W){1'b0}}, point_y, point_x};

endmodule
